/* rtl/lct_pkg.sv */
// Shared types, constants and helpers of the LRU cache table.
`default_nettype none

package lct_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int AGE_W   = IDX_W;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} lct_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} lct_cmd_t;

	// Clamp the capacity register to 1..ENTRIES
	function automatic logic [OCC_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [OCC_W-1:0] res;
		if (cap == '0) begin
			res = OCC_W'(1);
		end else if (32'(cap) > ENTRIES) begin
			res = OCC_W'(ENTRIES);
		end else begin
			res = OCC_W'(cap);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/lct_ctrl.sv */
// Controller state machine of the LRU cache table.
`default_nettype none

module lct_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lct_pkg::lct_cmd_t  cmd
);

	lct_pkg::lct_state_t state_q;
	lct_pkg::lct_state_t state_nxt;
	logic                out_valid_q;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lct_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Pick the next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lct_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = lct_pkg::ST_LOOKUP;
			end
			lct_pkg::ST_LOOKUP: begin
				state_nxt = lct_pkg::ST_UPDATE;
			end
			lct_pkg::ST_UPDATE: begin
				if (!out_valid_q || out_ready) state_nxt = lct_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lct_pkg::ST_IDLE;
			end
		endcase
	end

	// Drive handshake and datapath commands
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			lct_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			lct_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			lct_pkg::ST_UPDATE: begin
				cmd.commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/lct_datapath.sv */
// Datapath of the LRU cache table: entry store, key match, recency ages, result register.
`default_nettype none

module lct_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lct_pkg::lct_cmd_t              cmd,
	input  wire logic                           cfg_we,
	input  wire logic [lct_pkg::CAP_W-1:0]      cfg_wdata,
	input  wire logic                           mode,
	input  wire logic [lct_pkg::KEY_W-1:0]      lookup_key,
	input  wire logic [lct_pkg::VAL_W-1:0]      write_value,
	output logic                                hit,
	output logic [lct_pkg::VAL_W-1:0]           read_value,
	output logic                                evicted,
	output logic [lct_pkg::KEY_W-1:0]           evicted_key
);

	localparam int N = lct_pkg::ENTRIES;

	// Captured request
	logic                       mode_q;
	logic [lct_pkg::KEY_W-1:0]  key_q;
	logic [lct_pkg::VAL_W-1:0]  wval_q;
	logic [lct_pkg::CAP_W-1:0]  cap_q;

	// Entry store
	logic [lct_pkg::KEY_W-1:0]  key_mem_q [N];
	logic [lct_pkg::VAL_W-1:0]  val_mem_q [N];
	logic [N-1:0]               valid_q;
	logic [lct_pkg::AGE_W-1:0]  age_q [N];
	logic [lct_pkg::OCC_W-1:0]  occ_q;

	// Lookup results
	logic [N-1:0]               match;
	logic [N-1:0]               oldest;
	logic                       hit_c;
	logic                       full_c;
	logic                       free_c;
	logic [lct_pkg::IDX_W-1:0]  hit_idx;
	logic [lct_pkg::IDX_W-1:0]  old_idx;
	logic [lct_pkg::IDX_W-1:0]  free_idx;
	logic [lct_pkg::AGE_W-1:0]  occ_m1;

	logic                       hit_s1;
	logic                       new_s1;
	logic                       evict_s1;
	logic [lct_pkg::IDX_W-1:0]  slot_s1;
	logic [lct_pkg::AGE_W-1:0]  age_lim_s1;
	logic [lct_pkg::VAL_W-1:0]  rdval_s1;
	logic [lct_pkg::KEY_W-1:0]  evkey_s1;

	// Result register
	logic                       hit_q;
	logic [lct_pkg::VAL_W-1:0]  read_value_q;
	logic                       evicted_q;
	logic [lct_pkg::KEY_W-1:0]  evicted_key_q;

	// Compare every entry against the key; find the oldest and a free slot
	always_comb begin
		occ_m1 = lct_pkg::AGE_W'(occ_q - lct_pkg::OCC_W'(1));
		for (int i = 0; i < N; i++) begin
			match[i]  = valid_q[i] && (key_mem_q[i] == key_q);
			oldest[i] = valid_q[i] && (age_q[i] == occ_m1);
		end
		hit_c    = |match;
		free_c   = !(&valid_q);
		full_c   = occ_q >= lct_pkg::eff_cap(cap_q);
		hit_idx  = '0;
		old_idx  = '0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match[i])    hit_idx  = lct_pkg::IDX_W'(i);
			if (oldest[i])   old_idx  = lct_pkg::IDX_W'(i);
			if (!valid_q[i]) free_idx = lct_pkg::IDX_W'(i);
		end
	end

	// Capture the request beat and latch the lookup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		if (cmd.lookup) begin
			hit_s1     <= hit_c;
			new_s1     <= !hit_c && (mode_q == lct_pkg::MODE_PUT);
			evict_s1   <= !hit_c && (mode_q == lct_pkg::MODE_PUT) && full_c;
			age_lim_s1 <= age_q[hit_idx];
			rdval_s1   <= val_mem_q[hit_idx];
			evkey_s1   <= key_mem_q[old_idx];
			if (hit_c) begin
				slot_s1 <= hit_idx;
			end else if (full_c || !free_c) begin
				slot_s1 <= old_idx;
			end else begin
				slot_s1 <= free_idx;
			end
		end
	end

	// Write the value of the target slot on a put, and its key when the entry is new
	always_ff @(posedge clk) begin
		if (cmd.commit && (mode_q == lct_pkg::MODE_PUT)) begin
			val_mem_q[slot_s1] <= wval_q;
			if (new_s1) key_mem_q[slot_s1] <= key_q;
		end
	end

	// Update valid bits, ages, occupancy and the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= lct_pkg::CAP_W'(N);
			for (int i = 0; i < N; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.commit && (hit_s1 || new_s1)) begin
				for (int i = 0; i < N; i++) begin
					if (lct_pkg::IDX_W'(i) == slot_s1) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && (new_s1 || age_q[i] < age_lim_s1)) begin
						age_q[i] <= lct_pkg::AGE_W'(age_q[i] + lct_pkg::AGE_W'(1));
					end
				end
			end
			if (cmd.commit && new_s1) begin
				valid_q[slot_s1] <= 1'b1;
				if (!evict_s1) occ_q <= lct_pkg::OCC_W'(occ_q + lct_pkg::OCC_W'(1));
			end
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q     <= hit_s1;
			evicted_q <= evict_s1;
			if (mode_q == lct_pkg::MODE_PUT) begin
				read_value_q <= '0;
			end else if (hit_s1) begin
				read_value_q <= rdval_s1;
			end else begin
				read_value_q <= lct_pkg::READ_MISS;
			end
			evicted_key_q <= evict_s1 ? evkey_s1 : '0;
		end
	end

	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// Occupancy always counts the valid entries
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(occ_q))
		else $error("occupancy does not match valid entries");

	// Keys of valid entries are unique
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |-> $onehot0(match))
		else $error("key present in more than one entry");

	// An eviction replaces an entry without changing occupancy
	a_evict_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && evict_s1) |=> $stable(occ_q))
		else $error("occupancy changed on eviction");

	// Every lookup when full must find exactly one oldest entry
	a_oldest_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.lookup && full_c) |-> $onehot(oldest))
		else $error("no unique least recent entry");

endmodule

`default_nettype wire

/* rtl/lru_cache_table.sv */
// Top level of the LRU cache table: controller and datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | mode, lookup_key, write_value
//  out      | out_valid / out_ready | hit, read_value, evicted, evicted_key
//  cfg      | cfg_we                | cfg_wdata (capacity_in_use)
//
// Each request passes through capture, a parallel key compare over all
// entries, and the store/recency update that loads the result register.
// A new request is accepted after this update, even before the result drains.
// The update waits while the previous result beat is still not taken.
// Reset clears valid bits, ages and occupancy at once; no clearing pass.
`default_nettype none

module lru_cache_table (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               mode,
	input  wire logic signed [lct_pkg::KEY_W-1:0]   lookup_key,
	input  wire logic signed [lct_pkg::VAL_W-1:0]   write_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    hit,
	output logic signed [lct_pkg::VAL_W-1:0]        read_value,
	output logic                                    evicted,
	output logic signed [lct_pkg::KEY_W-1:0]        evicted_key,
	input  wire logic                               cfg_we,
	input  wire logic [lct_pkg::CAP_W-1:0]          cfg_wdata
);

	lct_pkg::lct_cmd_t cmd;

	lct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lct_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the LRU cache table: LRU mirror model and stimulus.
`timescale 1ns / 1ps

// Mirror of the cache contents and recency; holds the replies still owed by the block
class cache_mirror;
	typedef struct {
		logic                      hit;
		logic [lct_pkg::VAL_W-1:0] read_value;
		logic                      evicted;
		logic [lct_pkg::KEY_W-1:0] evicted_key;
	} reply_t;

	logic [lct_pkg::KEY_W-1:0] key_store[lct_pkg::ENTRIES];
	logic [lct_pkg::VAL_W-1:0] val_store[lct_pkg::ENTRIES];
	logic                      live[lct_pkg::ENTRIES];
	logic [lct_pkg::AGE_W-1:0] rank[lct_pkg::ENTRIES];
	int unsigned               fill;
	logic [lct_pkg::CAP_W-1:0] cap_reg;
	reply_t                    owed_replies[$];
	int                        mismatches;
	int                        requests;
	int                        replies;
	int                        hits;
	int                        evictions;

	function new();
		for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
			key_store[i] = '0;
			val_store[i] = '0;
			live[i] = 1'b0;
			rank[i] = '0;
		end
		fill = 0;
		cap_reg = lct_pkg::CAP_W'(16);
		mismatches = 0;
		requests = 0;
		replies = 0;
		hits = 0;
		evictions = 0;
	endfunction

	function void load_capacity(logic [lct_pkg::CAP_W-1:0] c);
		cap_reg = c;
	endfunction

	// Clamp the register to 1..ENTRIES
	function int unsigned room();
		int unsigned c;
		c = cap_reg;
		if (c == 0) c = 1;
		if (c > lct_pkg::ENTRIES) c = lct_pkg::ENTRIES;
		return c;
	endfunction

	// Age every live entry younger than limit, then make slot s the newest
	function void make_recent(int s, int unsigned limit);
		for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
			if (i != s && live[i] && rank[i] < limit) rank[i] = rank[i] + 1'b1;
		end
		rank[s] = '0;
	endfunction

	// Apply one accepted request beat and queue the reply it owes
	function void note_request(logic m, logic [lct_pkg::KEY_W-1:0] k,
			logic [lct_pkg::VAL_W-1:0] v);
		reply_t      r;
		int          s;
		int          slot;
		int unsigned oldest;
		r.hit = 1'b0;
		r.read_value = '0;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		s = -1;
		for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
			if (s < 0 && live[i] && key_store[i] == k) s = i;
		end
		if (m == lct_pkg::MODE_GET) begin
			if (s >= 0) begin
				r.hit = 1'b1;
				r.read_value = val_store[s];
				make_recent(s, rank[s]);
			end else begin
				r.read_value = lct_pkg::READ_MISS;
			end
		end else if (s >= 0) begin
			r.hit = 1'b1;
			val_store[s] = v;
			make_recent(s, rank[s]);
		end else begin
			slot = -1;
			oldest = 0;
			// Full: drop the least recent entry, lowest index on a tie
			if (fill >= room()) begin
				for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
					if (live[i] && (slot < 0 || rank[i] > oldest)) begin
						slot = i;
						oldest = rank[i];
					end
				end
				if (slot >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = key_store[slot];
					live[slot] = 1'b0;
					fill--;
				end
			end
			if (slot < 0) begin
				for (int i = lct_pkg::ENTRIES - 1; i >= 0; i--) begin
					if (!live[i]) slot = i;
				end
			end
			if (slot >= 0) begin
				key_store[slot] = k;
				val_store[slot] = v;
				live[slot] = 1'b1;
				fill++;
				make_recent(slot, lct_pkg::ENTRIES);
			end
		end
		if (r.hit) hits++;
		if (r.evicted) evictions++;
		requests++;
		owed_replies = {owed_replies, r};
	endfunction

	// Compare one reply beat against the oldest owed reply
	function void check_reply(logic h, logic [lct_pkg::VAL_W-1:0] rd, logic e,
			logic [lct_pkg::KEY_W-1:0] ek);
		reply_t w;
		replies++;
		if (owed_replies.size() == 0) begin
			$error("reply beat with no request outstanding");
			mismatches++;
			return;
		end
		w = owed_replies.pop_front();
		if (h !== w.hit) begin
			$error("hit: expected %0b, got %0b", w.hit, h);
			mismatches++;
		end
		if (rd !== w.read_value) begin
			$error("read_value: expected %h, got %h", w.read_value, rd);
			mismatches++;
		end
		if (e !== w.evicted) begin
			$error("evicted: expected %0b, got %0b", w.evicted, e);
			mismatches++;
		end
		if (ek !== w.evicted_key) begin
			$error("evicted_key: expected %h, got %h", w.evicted_key, ek);
			mismatches++;
		end
	endfunction

	function void close();
		if (owed_replies.size() != 0) begin
			$error("%0d replies never arrived", owed_replies.size());
			mismatches += owed_replies.size();
		end
	endfunction
endclass

module testbench;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 76;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             mode = lct_pkg::MODE_GET;
	logic signed [lct_pkg::KEY_W-1:0] lookup_key = '0;
	logic signed [lct_pkg::VAL_W-1:0] write_value = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             hit;
	logic signed [lct_pkg::VAL_W-1:0] read_value;
	logic                             evicted;
	logic signed [lct_pkg::KEY_W-1:0] evicted_key;
	logic                             cfg_we = 1'b0;
	logic [lct_pkg::CAP_W-1:0]        cfg_wdata = '0;

	cache_mirror mirror = new();
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;
	int          settings_used = 0;
	logic [lct_pkg::KEY_W-1:0] key_pool[$];

	lru_cache_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the reply channel at the current rate
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Record both channels at the rising edge; end the run if nothing moves
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				mirror.check_reply(hit, read_value, evicted, evicted_key);
			end
			if (in_valid && in_ready) begin
				mirror.note_request(mode, lookup_key, write_value);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no beat moved for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Present one request beat and hold it until accepted; called at a falling edge
	task automatic send_request(input logic m, input logic [lct_pkg::KEY_W-1:0] k,
			input logic [lct_pkg::VAL_W-1:0] v);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		lookup_key <= k;
		write_value <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed reply, then let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (mirror.owed_replies.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [lct_pkg::CAP_W-1:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror.load_capacity(c);
		settings_used++;
	endtask

	// One random burst: keys mostly from a pool a little larger than the capacity
	task automatic run_burst(input logic [lct_pkg::CAP_W-1:0] c, input int style);
		int                        pool_size;
		logic                      m;
		logic [lct_pkg::KEY_W-1:0] k;
		write_capacity(c);
		case (style % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 67;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 67;
			end
			default: begin
				send_idle_pct = 31;
				recv_stall_pct = 31;
			end
		endcase
		pool_size = mirror.room() + $urandom_range(1, 6);
		key_pool.delete();
		repeat (pool_size) key_pool = {key_pool, lct_pkg::KEY_W'($urandom())};
		repeat (PHASE_ITEMS) begin
			m = $urandom_range(1) ? lct_pkg::MODE_PUT : lct_pkg::MODE_GET;
			if ($urandom_range(99) < 85) begin
				k = key_pool[$urandom_range(pool_size - 1)];
			end else begin
				k = $urandom();
			end
			send_request(m, k, $urandom());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty lookup, extreme keys and values, update hit, get hit
		send_request(lct_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(lct_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lct_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lct_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(lct_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lct_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lct_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(lct_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);

		// Lower capacity below occupancy: each new key evicts one entry
		write_capacity(lct_pkg::CAP_W'(2));
		send_request(lct_pkg::MODE_PUT, 32'h0000_0005, 32'h5555_5555);
		send_request(lct_pkg::MODE_PUT, 32'h0000_0006, 32'hAAAA_AAAA);
		send_request(lct_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(lct_pkg::MODE_GET, 32'h0000_0005, 32'h0000_0000);
		send_request(lct_pkg::MODE_PUT, 32'h0000_0009, 32'h0000_0001);

		// Zero capacity acts as one entry
		write_capacity(lct_pkg::CAP_W'(0));
		send_request(lct_pkg::MODE_PUT, 32'h0000_0007, 32'h0000_0077);
		send_request(lct_pkg::MODE_GET, 32'h0000_0007, 32'h0000_0000);
		send_request(lct_pkg::MODE_PUT, 32'h0000_0007, 32'h0000_0078);
		send_request(lct_pkg::MODE_PUT, 32'h0000_0008, 32'h0000_0088);
		send_request(lct_pkg::MODE_GET, 32'h0000_0007, 32'h0000_0000);

		// Capacity above the table size clamps to the full table
		write_capacity(lct_pkg::CAP_W'(31));
		for (int i = 0; i < 5; i++) begin
			send_request(lct_pkg::MODE_PUT, lct_pkg::KEY_W'(32'h4000_0000 + i),
				lct_pkg::VAL_W'(i));
		end

		// Random bursts over a spread of capacities and idle patterns
		run_burst(lct_pkg::CAP_W'(1), 0);
		run_burst(lct_pkg::CAP_W'(16), 1);
		run_burst(lct_pkg::CAP_W'(3), 2);
		run_burst(lct_pkg::CAP_W'(31), 3);
		run_burst(lct_pkg::CAP_W'(8), 0);
		run_burst(lct_pkg::CAP_W'(0), 1);
		run_burst(lct_pkg::CAP_W'(12), 2);
		run_burst(lct_pkg::CAP_W'(17), 3);
		run_burst(lct_pkg::CAP_W'(5), 1);

		drain();
		mirror.close();
		$display("covered %0d requests and %0d replies across %0d capacity settings",
			mirror.requests, mirror.replies, settings_used);
		$display("lookups and updates that hit: %0d, entries evicted: %0d",
			mirror.hits, mirror.evictions);
		if (mirror.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/lct_pkg.sv
rtl/lct_ctrl.sv
rtl/lct_datapath.sv
rtl/lru_cache_table.sv
tb/testbench.sv
